@@ rtl/core/keypad_matrix_debouncer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keypad matrix debouncer
// Concurrent check helpers, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_MATRIX_DEBOUNCER_ASSERT_SVH
`define KEYPAD_MATRIX_DEBOUNCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KMD_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KMD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/kmd_pkg.sv @@
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types, codes and helpers of the keypad matrix debouncer.
// ----------------------------------------------------------------------------
package kmd_pkg;

    localparam int NUM_KEYS    = 9;
    localparam int NUM_COLUMNS = 3;

    localparam int CMD_W     = 2;
    localparam int KEY_W     = 4;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 2;
    localparam int MS_W      = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = 5;

    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLUMNS - 1);

    localparam logic [MS_W-1:0] DEBOUNCE_RESET = 16'd25;
    localparam logic [MS_W-1:0] PERIOD_RESET   = 16'd1;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_PERIOD_MS = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_EDGE  = 2'd1,
        CMD_ACK   = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESP,
        ST_REMAINDER
    } state_t;

    typedef struct packed {
        logic accept;
        logic cfg_write;
        logic exec;
        logic scan;
        logic respond;
        logic div_step;
    } ctl_cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic scan_last;
        logic div_last;
        logic out_free;
        logic cfg_is_period;
    } ctl_status_t;

    // Row of key k when column col is driven: (k - col) / 3, zero if negative.
    function automatic logic [COL_W-1:0] row_of(input logic [KEY_W-1:0] k,
                                                input logic [COL_W-1:0] col);
        logic [KEY_W:0] diff;
        logic [COL_W-1:0] row;
        diff = {1'b0, k} - {{(KEY_W-COL_W+1){1'b0}}, col};
        if (diff[KEY_W])
        begin
            row = 2'd0;
        end
        else if (diff >= 5'd6)
        begin
            row = 2'd2;
        end
        else if (diff >= 5'd3)
        begin
            row = 2'd1;
        end
        else
        begin
            row = 2'd0;
        end
        return row;
    endfunction

endpackage

@@ rtl/core/kmd_item_if.sv @@
// ----------------------------------------------------------------------------
// kmd_item_if
// Input item channel: command, key, row levels and hold limit.
// ----------------------------------------------------------------------------
interface kmd_item_if;
    logic                          valid;
    logic                          ready;
    logic [kmd_pkg::CMD_W-1:0]     cmd;
    logic [kmd_pkg::KEY_W-1:0]     key_index;
    logic [kmd_pkg::ROW_W-1:0]     row_levels;
    logic [kmd_pkg::MS_W-1:0]      hold_limit_ms;

    modport source (output valid, cmd, key_index, row_levels, hold_limit_ms, input ready);
    modport sink   (input valid, cmd, key_index, row_levels, hold_limit_ms, output ready);
endinterface

@@ rtl/core/kmd_result_if.sv @@
// ----------------------------------------------------------------------------
// kmd_result_if
// Result channel: column drive and the addressed key's status.
// ----------------------------------------------------------------------------
interface kmd_result_if;
    logic                          valid;
    logic                          ready;
    logic [kmd_pkg::COL_W-1:0]     active_column;
    logic [kmd_pkg::ROW_W-1:0]     column_drive;
    logic                          is_pressed;
    logic                          new_press;
    logic                          is_held;
    logic                          any_debouncing;

    modport source (output valid, active_column, column_drive, is_pressed, new_press,
                    is_held, any_debouncing, input ready);
    modport sink   (input valid, active_column, column_drive, is_pressed, new_press,
                    is_held, any_debouncing, output ready);
endinterface

@@ rtl/core/kmd_cfg_if.sv @@
// ----------------------------------------------------------------------------
// kmd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface kmd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [kmd_pkg::CFG_IDX_W-1:0] index;
    logic [kmd_pkg::MS_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/kmd_ctrl.sv @@
// ----------------------------------------------------------------------------
// kmd_ctrl
// Sequencer: accept, execute, key scan, respond, period remainder.
// ----------------------------------------------------------------------------
module kmd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  kmd_pkg::ctl_status_t status,
    output kmd_pkg::ctl_cmd_t    cmd
);

    kmd_pkg::state_t state_reg;
    kmd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        cfg_ready  = 1'b0;
        unique case (state_reg)
            kmd_pkg::ST_IDLE:
            begin
                // configuration wins over items
                cfg_ready  = 1'b1;
                item_ready = !cfg_valid;
                if (cfg_valid)
                begin
                    cmd.cfg_write = 1'b1;
                    if (status.cfg_is_period)
                    begin
                        state_next = kmd_pkg::ST_REMAINDER;
                    end
                end
                else if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = kmd_pkg::ST_EXEC;
                end
            end
            kmd_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.needs_scan ? kmd_pkg::ST_SCAN : kmd_pkg::ST_RESP;
            end
            kmd_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = kmd_pkg::ST_RESP;
                end
            end
            kmd_pkg::ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = kmd_pkg::ST_IDLE;
                end
            end
            kmd_pkg::ST_REMAINDER:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = kmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kmd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/kmd_datapath.sv @@
// ----------------------------------------------------------------------------
// kmd_datapath
// Key state, time base, column phase, remainder unit and result register.
// ----------------------------------------------------------------------------
module kmd_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  kmd_pkg::ctl_cmd_t                cmd,
    output kmd_pkg::ctl_status_t             status,
    input  logic [kmd_pkg::CMD_W-1:0]        item_cmd,
    input  logic [kmd_pkg::KEY_W-1:0]        item_key,
    input  logic [kmd_pkg::ROW_W-1:0]        item_rows,
    input  logic [kmd_pkg::MS_W-1:0]         item_limit,
    input  logic [kmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kmd_pkg::MS_W-1:0]         cfg_data,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [kmd_pkg::COL_W-1:0]        out_column,
    output logic [kmd_pkg::ROW_W-1:0]        out_drive,
    output logic                             out_pressed,
    output logic                             out_new_press,
    output logic                             out_held,
    output logic                             out_debouncing
);

    localparam int NK = kmd_pkg::NUM_KEYS;
    localparam int TW = kmd_pkg::TIME_W;
    localparam int MW = kmd_pkg::MS_W;

    // configuration
    logic [MW-1:0] debounce_reg;
    logic [MW-1:0] period_reg;

    // latched item
    kmd_pkg::cmd_t                cmd_reg;
    logic [kmd_pkg::KEY_W-1:0]    key_reg;
    logic [kmd_pkg::ROW_W-1:0]    rows_reg;
    logic [MW-1:0]                limit_reg;

    // block state
    logic [TW-1:0]                time_reg;
    logic [MW-1:0]                phase_reg;
    logic                         active_reg;
    logic [kmd_pkg::COL_W-1:0]    col_reg;
    logic [NK-1:0]                busy_reg;
    logic [NK-1:0]                down_reg;
    logic [NK-1:0]                latch_reg;
    logic [TW-1:0]                deb_start_reg [NK];
    logic [TW-1:0]                hold_start_reg [NK];

    // sequencing
    logic [kmd_pkg::KEY_W-1:0]     scan_key_reg;
    logic [kmd_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [MW-1:0]                 rem_reg;
    logic [MW-1:0]                 rem_next;

    // result register
    logic                          out_valid_reg;

    logic [MW-1:0]                 pmod;
    logic [MW:0]                   phase_inc;
    logic [MW-1:0]                 phase_next;
    logic [MW:0]                   rem_shift;
    logic                          any_busy;
    logic                          key_ok;
    logic [kmd_pkg::COL_W-1:0]     col_next;
    logic                          scan_due;
    logic                          scan_pressed;
    logic [TW-1:0]                 held_span;
    logic                          key_down_sel;

    assign pmod      = (period_reg == '0) ? MW'(1) : period_reg;
    assign any_busy  = |busy_reg;
    assign key_ok    = (key_reg <= kmd_pkg::LAST_KEY);
    assign col_next  = (col_reg == kmd_pkg::LAST_COL) ? '0 : col_reg + 1'b1;

    // the time base wrapping to zero lands on a multiple of every period
    assign phase_inc  = {1'b0, phase_reg} + 1'b1;
    assign phase_next = ((phase_inc == {1'b0, pmod}) || (time_reg == '1)) ? '0
                                                                          : phase_inc[MW-1:0];

    // restoring remainder step: shift in one bit of the time, subtract if it fits
    assign rem_shift = {rem_reg, time_reg[div_cnt_reg]};
    assign rem_next  = (rem_shift >= {1'b0, pmod}) ? MW'(rem_shift - {1'b0, pmod})
                                                   : rem_shift[MW-1:0];

    assign scan_due = busy_reg[scan_key_reg] &&
                      ((time_reg - deb_start_reg[scan_key_reg]) >= {{(TW-MW){1'b0}}, debounce_reg});
    assign scan_pressed = !rows_reg[kmd_pkg::row_of(scan_key_reg, col_reg)];

    assign key_down_sel = key_ok ? down_reg[key_reg] : 1'b0;
    assign held_span    = key_ok ? (time_reg - hold_start_reg[key_reg]) : '0;

    assign status.needs_scan    = (cmd_reg == kmd_pkg::CMD_TICK) && active_reg;
    assign status.scan_last     = (scan_key_reg == kmd_pkg::LAST_KEY);
    assign status.div_last      = (div_cnt_reg == '0);
    assign status.out_free      = !out_valid_reg || out_ready;
    assign status.cfg_is_period = (cfg_index == kmd_pkg::REG_COLUMN_PERIOD_MS);

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg   <= kmd_pkg::cmd_t'(item_cmd);
            key_reg   <= item_key;
            rows_reg  <= item_rows;
            limit_reg <= item_limit;
        end
        if (cmd.cfg_write)
        begin
            rem_reg     <= '0;
            div_cnt_reg <= kmd_pkg::DIV_CNT_W'(TW - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
        if (cmd.exec)
        begin
            scan_key_reg <= '0;
        end
        else if (cmd.scan)
        begin
            scan_key_reg <= scan_key_reg + 1'b1;
        end
        if (cmd.exec && cmd_reg == kmd_pkg::CMD_EDGE && key_ok)
        begin
            deb_start_reg[key_reg] <= time_reg;
        end
        if (cmd.respond)
        begin
            out_column     <= col_reg;
            out_drive      <= ~(kmd_pkg::ROW_W'(1) << col_reg);
            out_pressed    <= key_down_sel;
            out_new_press  <= key_ok ? latch_reg[key_reg] : 1'b0;
            out_held       <= key_down_sel && (held_span >= {{(TW-MW){1'b0}}, limit_reg});
            out_debouncing <= any_busy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= kmd_pkg::DEBOUNCE_RESET;
            period_reg    <= kmd_pkg::PERIOD_RESET;
            time_reg      <= '0;
            phase_reg     <= '0;
            active_reg    <= 1'b0;
            col_reg       <= '0;
            busy_reg      <= '0;
            down_reg      <= '0;
            latch_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NK; k++)
            begin
                hold_start_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.cfg_write)
            begin
                case (cfg_index)
                    kmd_pkg::REG_DEBOUNCE_MS:      debounce_reg <= cfg_data;
                    kmd_pkg::REG_COLUMN_PERIOD_MS: period_reg   <= cfg_data;
                    default:                       ;
                endcase
            end
            if (cmd.div_step && status.div_last)
            begin
                phase_reg <= rem_next;
            end
            if (cmd.exec)
            begin
                case (cmd_reg)
                    kmd_pkg::CMD_TICK:
                    begin
                        time_reg   <= time_reg + 1'b1;
                        phase_reg  <= phase_next;
                        active_reg <= any_busy;
                        if (!active_reg && !any_busy && phase_next == '0)
                        begin
                            col_reg <= col_next;
                        end
                    end
                    kmd_pkg::CMD_EDGE:
                    begin
                        if (key_ok)
                        begin
                            busy_reg[key_reg] <= 1'b1;
                        end
                    end
                    kmd_pkg::CMD_ACK:
                    begin
                        if (key_ok)
                        begin
                            latch_reg[key_reg] <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.scan && scan_due)
            begin
                busy_reg[scan_key_reg] <= 1'b0;
                if (scan_pressed != down_reg[scan_key_reg])
                begin
                    down_reg[scan_key_reg] <= scan_pressed;
                    if (scan_pressed)
                    begin
                        latch_reg[scan_key_reg]      <= 1'b1;
                        hold_start_reg[scan_key_reg] <= time_reg;
                    end
                end
            end
            if (cmd.respond)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/keypad_matrix_debouncer.sv @@
// ----------------------------------------------------------------------------
// keypad_matrix_debouncer
// Debouncer and column scanner for a 3x3 active-low key matrix.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one beat per command (tick, edge event, acknowledge, query).
//            Ticks carry the row pin levels sampled once per millisecond.
//   result : exactly one beat per item, showing the column drive and the
//            addressed key's status after the item has taken effect.
//   cfg    : register writes (0 debounce_ms, 1 column_period_ms); other
//            indexes are acknowledged and dropped. Write only while idle.
// Sequence:
//   A tick in the active state is accepted, executed, then scanned one key
//   per cycle through the shared elapsed-time comparator over all nine keys,
//   then given its result. Every other item is accepted, executed and given
//   its result. A column_period_ms write holds both ready lines low while a
//   bit-serial remainder rebuilds the column phase from the current time.
// Reset: time, column, key states, latches and hold starts clear; registers
//   return to debounce 25 ms and column period 1 ms.
// Stall: the result register holds its beat while the receiver stalls; the
//   next item is still accepted and waits in its result cycle.
// ----------------------------------------------------------------------------
`include "keypad_matrix_debouncer_assert.svh"

module keypad_matrix_debouncer
(
    input  logic          clk,
    input  logic          rst_n,
    kmd_item_if.sink      item,
    kmd_result_if.source  result,
    kmd_cfg_if.sink       cfg
);

    kmd_pkg::ctl_cmd_t    ctl_cmd;
    kmd_pkg::ctl_status_t ctl_status;

    // Sequencer: owns both ready lines and steps the datapath.
    kmd_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .cfg_valid  (cfg.valid),
        .cfg_ready  (cfg.ready),
        .status     (ctl_status),
        .cmd        (ctl_cmd)
    );

    // Datapath: key state, time base and the result register.
    kmd_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl_cmd),
        .status         (ctl_status),
        .item_cmd       (item.cmd),
        .item_key       (item.key_index),
        .item_rows      (item.row_levels),
        .item_limit     (item.hold_limit_ms),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_ready      (result.ready),
        .out_valid      (result.valid),
        .out_column     (result.active_column),
        .out_drive      (result.column_drive),
        .out_pressed    (result.is_pressed),
        .out_new_press  (result.new_press),
        .out_held       (result.is_held),
        .out_debouncing (result.any_debouncing)
    );

    // One item in flight: the block goes busy right after an accepted beat.
    `KMD_ASSERT_NEXT(a_busy_after_item, clk, rst_n, item.valid && item.ready, !item.ready,
        "item accepted while previous item still in work")

    // A period write starts the remainder pass and blocks items.
    `KMD_ASSERT_NEXT(a_busy_after_period, clk, rst_n,
        cfg.valid && cfg.ready && cfg.index == kmd_pkg::REG_COLUMN_PERIOD_MS,
        !item.ready && !cfg.ready, "period write did not start remainder pass")

    // Exactly one column driven low, and it matches the reported column.
    `KMD_ASSERT_SAME(a_one_column, clk, rst_n, result.valid,
        $countones(result.column_drive) == 2 && !result.column_drive[result.active_column],
        "column drive does not match active column")

    // A held key must also be reported as pressed.
    `KMD_ASSERT_SAME(a_held_pressed, clk, rst_n, result.valid && result.is_held,
        result.is_pressed, "held key reported as released")

endmodule

@@ dv/tb_keypad_matrix_debouncer.sv @@
// ----------------------------------------------------------------------------
// tb_keypad_matrix_debouncer
// Self-checking bench for the 3x3 keypad debouncer. A short table of directed
// beats covers reset state, column rotation, debounce restart, invalid keys
// and a zero column period. Six random segments follow, each with its own
// register setting, in pairs per idle pattern. Each result beat is checked
// against a typed value or a behavioral scanner model run on accepted beats.
// ----------------------------------------------------------------------------
module tb_keypad_matrix_debouncer;
    import kmd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;   // acknowledged, no register
    localparam int QUIET_LIMIT = 4000;
    localparam int SEG_COUNT   = 6;
    localparam int SEG_BEATS   = 210;
    localparam int SETTLE_WAIT = 30;

    // Register settings per random segment, extremes included.
    localparam logic [MS_W-1:0] SEG_DEBOUNCE [SEG_COUNT] =
        '{16'd3, 16'd0, 16'hFFFF, 16'd1, 16'd5, 16'd2};
    localparam logic [MS_W-1:0] SEG_PERIOD [SEG_COUNT] =
        '{16'd2, 16'd1, 16'hFFFF, 16'd0, 16'd3, 16'd7};

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] drive;
        logic             pressed;
        logic             fresh;
        logic             held;
        logic             busy;
    } key_status_t;

    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [MS_W-1:0]      reg_data;
        cmd_t                 cmd;
        logic [KEY_W-1:0]     key;
        logic [ROW_W-1:0]     rows;
        logic [MS_W-1:0]      limit;
        logic                 typed;
        key_status_t          want;
    } plan_row_t;

    localparam key_status_t NO_STATUS   = '0;
    localparam key_status_t COL0_QUIET  = '{2'd0, 3'b110, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam key_status_t COL1_QUIET  = '{2'd1, 3'b101, 1'b0, 1'b0, 1'b0, 1'b0};

    localparam int PLAN_LEN = 27;

    // Directed beats. Typed expectations only where the value is obvious;
    // the rest are checked against the model.
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // reset state, then an out-of-range key with row levels off a tick
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_QUERY, 4'd0,  3'b000, 16'h0000, 1'b1, COL0_QUIET},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_QUERY, 4'd15, 3'b111, 16'hFFFF, 1'b1, COL0_QUIET},
        // period 1: every tick rotates the column
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b111, 16'h0000, 1'b1, COL1_QUIET},
        '{1'b1, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b000, 16'h0000, 1'b0, NO_STATUS},
        '{1'b1, REG_SPARE,       16'hFFFF, CMD_TICK,  4'd0,  3'b000, 16'h0000, 1'b0, NO_STATUS},
        // zero debounce: press key 1 on column 1
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_EDGE,  4'd1,  3'b000, 16'hFFFF, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b111, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b110, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_QUERY, 4'd1,  3'b000, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_QUERY, 4'd1,  3'b000, 16'hFFFF, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_ACK,   4'd1,  3'b000, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_ACK,   4'd9,  3'b000, 16'h0000, 1'b0, NO_STATUS},
        // edge on a key that is already settling restarts it
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_EDGE,  4'd4,  3'b000, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_EDGE,  4'd4,  3'b111, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b111, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b000, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b111, 16'h0000, 1'b0, NO_STATUS},
        // key left of the driven column: negative difference maps to row 0
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_EDGE,  4'd1,  3'b000, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b111, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b111, 16'h0000, 1'b0, NO_STATUS},
        // zero column period behaves as one
        '{1'b1, REG_COLUMN_PERIOD_MS, 16'h0000, CMD_TICK, 4'd0, 3'b000, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b111, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b111, 16'h0000, 1'b0, NO_STATUS},
        // all rows low: key 8 sits on row 2
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_EDGE,  4'd8,  3'b000, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b000, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_TICK,  4'd0,  3'b000, 16'h0000, 1'b0, NO_STATUS},
        '{1'b0, REG_DEBOUNCE_MS, 16'h0000, CMD_QUERY, 4'd8,  3'b000, 16'h0000, 1'b0, NO_STATUS}
    };

    logic clk;
    logic rst_n;

    kmd_item_if   item_ch ();
    kmd_result_if result_ch ();
    kmd_cfg_if    cfg_ch ();

    keypad_matrix_debouncer uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // ------------------------------------------------------------------------
    // Scanner model state
    // ------------------------------------------------------------------------
    logic [MS_W-1:0]     debounce_cfg;
    logic [MS_W-1:0]     period_cfg;
    logic [TIME_W-1:0]   now_ms;
    logic                scanning;
    logic [COL_W-1:0]    column_q;
    logic [NUM_KEYS-1:0] settling;
    logic [NUM_KEYS-1:0] down;
    logic [NUM_KEYS-1:0] latched;
    logic [TIME_W-1:0]   settle_since [NUM_KEYS];
    logic [TIME_W-1:0]   held_since [NUM_KEYS];

    key_status_t pending_status [$];
    int          mismatches;
    int          beats_sent;
    int          quiet_cycles;
    int          src_gap_pct;
    int          snk_stall_pct;

    // Row a key sits on while column col is driven; left of the column is row 0.
    function automatic int row_for(int k, int col);
        int diff;
        diff = k - col;
        return (diff < 0) ? 0 : diff / 3;
    endfunction

    // Wrapping millisecond difference against a 16-bit limit.
    function automatic logic elapsed_ms(logic [TIME_W-1:0] start, logic [MS_W-1:0] limit);
        logic [TIME_W-1:0] span;
        span = now_ms - start;
        return span >= {{(TIME_W-MS_W){1'b0}}, limit};
    endfunction

    // Advance the model by one accepted item beat and report the status after it.
    task automatic advance_keypad(input cmd_t cmd, input logic [KEY_W-1:0] key,
                                  input logic [ROW_W-1:0] rows,
                                  input logic [MS_W-1:0] limit,
                                  output key_status_t st);
        logic              ok;
        int                idx;
        logic              hit;
        logic [TIME_W-1:0] per;
        ok  = key < NUM_KEYS;
        idx = ok ? int'(key) : 0;
        case (cmd)
            CMD_TICK:
            begin
                now_ms = now_ms + 1;
                if (!scanning)
                begin
                    // idle: wake on any settling key, otherwise rotate on the period
                    if (settling != '0)
                    begin
                        scanning = 1'b1;
                    end
                    else
                    begin
                        per = (period_cfg == '0) ? 1 : {{(TIME_W-MS_W){1'b0}}, period_cfg};
                        if (now_ms % per == 0)
                        begin
                            column_q = (column_q == LAST_COL) ? '0 : column_q + 1'b1;
                        end
                    end
                end
                else
                begin
                    // active: stay active while any key was settling at this tick
                    scanning = 1'b0;
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        if (settling[k])
                        begin
                            scanning = 1'b1;
                            if (elapsed_ms(settle_since[k], debounce_cfg))
                            begin
                                hit = !rows[row_for(k, column_q)];
                                if (hit != down[k])
                                begin
                                    down[k] = hit;
                                    if (hit)
                                    begin
                                        latched[k]    = 1'b1;
                                        held_since[k] = now_ms;
                                    end
                                end
                                settling[k] = 1'b0;
                            end
                        end
                    end
                end
            end
            CMD_EDGE:
            begin
                if (ok)
                begin
                    settling[idx]     = 1'b1;
                    settle_since[idx] = now_ms;
                end
            end
            CMD_ACK:
            begin
                if (ok)
                begin
                    latched[idx] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        st.column  = column_q;
        st.drive   = ~(3'b001 << column_q);
        st.pressed = ok && down[idx];
        st.fresh   = ok && latched[idx];
        st.held    = ok && down[idx] && elapsed_ms(held_since[idx], limit);
        st.busy    = settling != '0;
    endtask

    function automatic void cmp_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Hold limit: often short so held flips, sometimes the extreme, else random.
    function automatic logic [MS_W-1:0] pick_limit();
        int r;
        r = $urandom_range(99);
        if (r < 40)
        begin
            return MS_W'($urandom_range(4));
        end
        else if (r < 55)
        begin
            return 16'hFFFF;
        end
        return MS_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Item driver: drive at the falling edge, accept at the rising edge
    // ------------------------------------------------------------------------
    task automatic send_item(input cmd_t cmd, input logic [KEY_W-1:0] key,
                             input logic [ROW_W-1:0] rows, input logic [MS_W-1:0] limit,
                             input logic typed = 1'b0, input key_status_t want = '0);
        key_status_t st;
        @(negedge clk);
        // drop valid for a random gap before this beat
        while ($urandom_range(99) < src_gap_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.cmd           = cmd;
        item_ch.key_index     = key;
        item_ch.row_levels    = rows;
        item_ch.hold_limit_ms = limit;
        item_ch.valid         = 1'b1;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        advance_keypad(cmd, key, rows, limit, st);
        pending_status.push_back(typed ? want : st);
        beats_sent++;
    endtask

    // Drop valid and wait until every expected result beat has arrived.
    task automatic drain();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (pending_status.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Register write, only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] data);
        drain();
        @(negedge clk);
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        cfg_ch.valid = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        if (idx == REG_DEBOUNCE_MS)
        begin
            debounce_cfg = data;
        end
        else if (idx == REG_COLUMN_PERIOD_MS)
        begin
            period_cfg = data;
        end
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Edge on one key, then ticks with its row held to the wanted level, enough
    // for a debounce of up to 6 ms to expire, then maybe look at it and ack it.
    task automatic press_sequence();
        int               k;
        logic             want_down;
        int               n;
        logic [ROW_W-1:0] rows;
        k         = ($urandom_range(9) == 0) ? $urandom_range(15, NUM_KEYS) : $urandom_range(8);
        want_down = ($urandom_range(1) == 1);
        send_item(CMD_EDGE, KEY_W'(k), ROW_W'($urandom), pick_limit());
        if ($urandom_range(3) == 0)
        begin
            send_item(CMD_QUERY, KEY_W'(k), ROW_W'($urandom), pick_limit());
        end
        n = ((debounce_cfg < 6) ? int'(debounce_cfg) : 6) + 2 + $urandom_range(2);
        repeat (n)
        begin
            rows = ROW_W'($urandom);
            if (k < NUM_KEYS)
            begin
                rows[row_for(k, column_q)] = !want_down;
            end
            send_item(CMD_TICK, KEY_W'($urandom), rows, pick_limit());
        end
        if ($urandom_range(1) == 0)
        begin
            send_item(CMD_QUERY, KEY_W'(k), ROW_W'($urandom), pick_limit());
        end
        if ($urandom_range(2) == 0)
        begin
            send_item(CMD_ACK, KEY_W'(k), ROW_W'($urandom), pick_limit());
            send_item(CMD_QUERY, KEY_W'(k), ROW_W'($urandom), pick_limit());
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock and result side
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Stall the result channel at random, changed on the falling edge.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready = rst_n && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Check each accepted result beat against the oldest expectation and
    // count cycles in which no channel moves a beat.
    always @(posedge clk)
    begin
        key_status_t want;
        key_status_t got;
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got = '{result_ch.active_column, result_ch.column_drive, result_ch.is_pressed,
                        result_ch.new_press, result_ch.is_held, result_ch.any_debouncing};
                if (pending_status.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got %h", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = pending_status.pop_front();
                    cmp_field("active_column",  int'(want.column),  int'(got.column));
                    cmp_field("column_drive",   int'(want.drive),   int'(got.drive));
                    cmp_field("is_pressed",     int'(want.pressed), int'(got.pressed));
                    cmp_field("new_press",      int'(want.fresh),   int'(got.fresh));
                    cmp_field("is_held",        int'(want.held),    int'(got.held));
                    cmp_field("any_debouncing", int'(want.busy),    int'(got.busy));
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("tb_keypad_matrix_debouncer: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int seg_start;
        rst_n                 = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.cmd           = CMD_QUERY;
        item_ch.key_index     = '0;
        item_ch.row_levels    = '0;
        item_ch.hold_limit_ms = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_DEBOUNCE_MS;
        cfg_ch.data           = '0;
        mismatches            = 0;
        beats_sent            = 0;
        quiet_cycles          = 0;
        src_gap_pct           = 10;
        snk_stall_pct         = 59;

        // model reset state
        debounce_cfg = DEBOUNCE_RESET;
        period_cfg   = PERIOD_RESET;
        now_ms       = '0;
        scanning     = 1'b0;
        column_q     = '0;
        settling     = '0;
        down         = '0;
        latched      = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            settle_since[k] = '0;
            held_since[k]   = '0;
        end

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table; register rows wait for an idle block.
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (PLAN[i].is_write)
            begin
                write_reg(PLAN[i].reg_idx, PLAN[i].reg_data);
            end
            else
            begin
                send_item(PLAN[i].cmd, PLAN[i].key, PLAN[i].rows, PLAN[i].limit,
                          PLAN[i].typed, PLAN[i].want);
            end
        end

        // Random segments: receiver stalls first, then sender idles, then neither.
        for (int s = 0; s < SEG_COUNT; s++)
        begin
            write_reg(REG_DEBOUNCE_MS, SEG_DEBOUNCE[s]);
            write_reg(REG_COLUMN_PERIOD_MS, SEG_PERIOD[s]);
            src_gap_pct   = (s < 2) ? 10 : (s < 4) ? 59 : 0;
            snk_stall_pct = (s < 2) ? 59 : (s < 4) ? 10 : 0;
            seg_start     = beats_sent;
            while (beats_sent - seg_start < SEG_BEATS)
            begin
                if ($urandom_range(99) < 70)
                begin
                    press_sequence();
                end
                else
                begin
                    send_item(cmd_t'($urandom_range(3)), KEY_W'($urandom), ROW_W'($urandom),
                              pick_limit());
                end
            end
        end

        // Let the last beats come back, then keep watching for strays before the check.
        drain();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (pending_status.size() != 0)
        begin
            $display("%0t: %0d result beats never arrived", $time, pending_status.size());
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("tb_keypad_matrix_debouncer: done, clean");
        end
        else
        begin
            $display("tb_keypad_matrix_debouncer: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/kmd_pkg.sv
rtl/core/kmd_item_if.sv
rtl/core/kmd_result_if.sv
rtl/core/kmd_cfg_if.sv
rtl/core/kmd_ctrl.sv
rtl/core/kmd_datapath.sv
rtl/core/keypad_matrix_debouncer.sv
dv/tb_keypad_matrix_debouncer.sv
